// ===== hdl/ppe_pkg.sv =====
// ppe_pkg: sizes, codes, command/status structs and saturation helper for the
// piecewise polynomial evaluator; no dependencies, used by every other file
package ppe_pkg;

  // sizing
  localparam int MAX_PIECES  = 4;
  localparam int MAX_ORDER   = 7;
  localparam int PARAM_SLOTS = 32;
  localparam int FRAC_BITS   = 16;

  // fixed field widths
  localparam int WORD_W      = 32;
  localparam int ACTION_W    = 2;
  localparam int SLOT_W      = 5;
  localparam int COUNT_W     = 3;
  localparam int ORDERS_W    = 12;
  localparam int ORD_FIELD_W = 3;
  localparam int BREAK_REGS  = 5;
  localparam int CFG_IDX_W   = 3;

  // derived widths
  localparam int COEF_ROW   = MAX_ORDER + 1;
  localparam int COEF_DEPTH = MAX_PIECES * COEF_ROW;
  localparam int CA_W       = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
  localparam int PS_AW      = $clog2(PARAM_SLOTS);
  localparam int ORD_W      = $clog2(COEF_ROW);
  localparam int PC_W       = $clog2(MAX_PIECES + 1);
  localparam int PIDX_W     = $clog2(COEF_DEPTH + 1);
  localparam int BI_W       = $clog2(BREAK_REGS);
  localparam int T_W        = WORD_W + 1;
  localparam int PROD_W     = WORD_W + T_W;
  localparam int WIDE_W     = PROD_W + 1;
  localparam int SUM_W      = WORD_W + $clog2(MAX_PIECES) + 1;
  localparam int PIECE_LIM  = (MAX_PIECES < BREAK_REGS - 1) ? MAX_PIECES : BREAK_REGS - 1;

  // request actions
  localparam logic [ACTION_W-1:0] ACT_WRITE  = ACTION_W'(0);
  localparam logic [ACTION_W-1:0] ACT_DERIVE = ACTION_W'(1);
  localparam logic [ACTION_W-1:0] ACT_EVAL   = ACTION_W'(2);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PIECE_COUNT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PIECE_ORDERS = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_BREAK_0      = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_BREAK_1      = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_BREAK_2      = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_BREAK_3      = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] CFG_BREAK_4      = CFG_IDX_W'(6);

  // register reset values
  localparam logic [COUNT_W-1:0]  RST_PIECE_COUNT  = COUNT_W'(1);
  localparam logic [ORDERS_W-1:0] RST_PIECE_ORDERS = ORDERS_W'(7);
  localparam logic signed [WORD_W-1:0] RST_BREAKS [BREAK_REGS] = '{
    32'shFFFF_0000, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000
  };

  localparam logic signed [WIDE_W-1:0] WIDE_WORD_MAX =
    WIDE_W'($signed({1'b0, {(WORD_W-1){1'b1}}}));
  localparam logic signed [WIDE_W-1:0] WIDE_WORD_MIN =
    WIDE_W'($signed({1'b1, {(WORD_W-1){1'b0}}}));
  localparam logic signed [WIDE_W-1:0] WIDE_HALF = WIDE_W'(1) <<< (FRAC_BITS - 1);

  typedef struct packed {
    logic                     clip;
    logic signed [WORD_W-1:0] value;
  } sat_word_t;

  // controller to datapath
  typedef struct packed {
    logic param_wr;
    logic start_derive;
    logic start_eval;
    logic piece_begin;
    logic pc_inc;
    logic coef_wr;
    logic rd_top;
    logic h_load;
    logic h_mul;
    logic h_add;
    logic slope;
    logic save_val;
    logic save_slope;
    logic sum_add;
    logic out_load;
  } ppe_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pc_at_n;
    logic pc_at_max;
    logic in_range;
    logic fill_last;
    logic fill_used;
    logic load_last;
    logic add_last;
    logic ord_zero;
    logic out_free;
  } ppe_stat_t;

  function automatic sat_word_t sat_word(input logic signed [WIDE_W-1:0] v);
    sat_word_t r;
    if (v > WIDE_WORD_MAX) begin
      r.clip  = 1'b1;
      r.value = {1'b0, {(WORD_W-1){1'b1}}};
    end else if (v < WIDE_WORD_MIN) begin
      r.clip  = 1'b1;
      r.value = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      r.clip  = 1'b0;
      r.value = WORD_W'(v);
    end
    return r;
  endfunction

endpackage

// ===== hdl/ppe_ifs.sv =====
// ppe channel interfaces: request, result and register write channels
// depends on ppe_pkg for field widths
interface ppe_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [ppe_pkg::ACTION_W-1:0]         action;
  logic [ppe_pkg::SLOT_W-1:0]           param_index;
  logic signed [ppe_pkg::WORD_W-1:0]    operand_value;
  modport source (output valid, action, param_index, operand_value, input ready);
  modport sink   (input valid, action, param_index, operand_value, output ready);
endinterface

interface ppe_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ppe_pkg::WORD_W-1:0]    response;
  logic                                 saturated;
  modport source (output valid, response, saturated, input ready);
  modport sink   (input valid, response, saturated, output ready);
endinterface

interface ppe_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [ppe_pkg::CFG_IDX_W-1:0]        index;
  logic [ppe_pkg::WORD_W-1:0]           data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/ppe_ctrl.sv =====
// ppe_ctrl: sequencer for write, derive and evaluate requests
// depends on ppe_pkg; drives ppe_dpath through ppe_cmd_t, reads ppe_stat_t
module ppe_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [ppe_pkg::ACTION_W-1:0]  in_action,
  output logic                          in_ready,
  input  ppe_pkg::ppe_stat_t            stat,
  output ppe_pkg::ppe_cmd_t             cmd
);

  typedef enum logic [10:0] {
    ST_IDLE      = 11'b000_0000_0001,
    ST_D_PIECE   = 11'b000_0000_0010,
    ST_D_FILL_RD = 11'b000_0000_0100,
    ST_D_FILL_WR = 11'b000_0000_1000,
    ST_E_PIECE   = 11'b000_0001_0000,
    ST_H_LOAD_RD = 11'b000_0010_0000,
    ST_H_LOAD    = 11'b000_0100_0000,
    ST_H_MUL     = 11'b000_1000_0000,
    ST_H_ADD     = 11'b001_0000_0000,
    ST_H_DONE    = 11'b010_0000_0000,
    ST_DONE      = 11'b100_0000_0000
  } state_t;

  // what the horner pass is computing
  typedef enum logic [2:0] {
    PH_DVAL   = 3'b001,
    PH_DSLOPE = 3'b010,
    PH_EVAL   = 3'b100
  } phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_DVAL;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.slope = (phase_r == PH_DSLOPE);
    in_ready  = 1'b0;
    state_nxt = state_r;
    phase_nxt = phase_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_action)
            ppe_pkg::ACT_WRITE: begin
              cmd.param_wr = 1'b1;
            end
            ppe_pkg::ACT_DERIVE: begin
              cmd.start_derive = 1'b1;
              phase_nxt        = PH_DVAL;
              state_nxt        = ST_D_PIECE;
            end
            ppe_pkg::ACT_EVAL: begin
              cmd.start_eval = 1'b1;
              phase_nxt      = PH_EVAL;
              state_nxt      = ST_E_PIECE;
            end
            default: ;
          endcase
        end
      end
      ST_D_PIECE: begin
        if (stat.pc_at_max) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.piece_begin = 1'b1;
          state_nxt       = ST_D_FILL_RD;
        end
      end
      // wait state for the registered parameter read to land
      ST_D_FILL_RD: begin
        state_nxt = ST_D_FILL_WR;
      end
      ST_D_FILL_WR: begin
        cmd.coef_wr = 1'b1;
        if (!stat.fill_last) begin
          state_nxt = ST_D_FILL_RD;
        end else if (stat.fill_used) begin
          state_nxt = ST_H_LOAD_RD;
        end else begin
          cmd.pc_inc = 1'b1;
          state_nxt  = ST_D_PIECE;
        end
      end
      ST_E_PIECE: begin
        if (stat.pc_at_n) begin
          state_nxt = ST_DONE;
        end else if (stat.in_range) begin
          cmd.piece_begin = 1'b1;
          state_nxt       = ST_H_LOAD_RD;
        end else begin
          cmd.pc_inc = 1'b1;
        end
      end
      ST_H_LOAD_RD: begin
        cmd.rd_top = 1'b1;
        state_nxt  = ST_H_LOAD;
      end
      ST_H_LOAD: begin
        cmd.h_load = 1'b1;
        state_nxt  = stat.load_last ? ST_H_DONE : ST_H_MUL;
      end
      ST_H_MUL: begin
        cmd.h_mul = 1'b1;
        state_nxt = ST_H_ADD;
      end
      ST_H_ADD: begin
        cmd.h_add = 1'b1;
        state_nxt = stat.add_last ? ST_H_DONE : ST_H_MUL;
      end
      ST_H_DONE: begin
        unique case (phase_r)
          PH_DVAL: begin
            cmd.save_val = 1'b1;
            if (stat.ord_zero) begin
              // constant piece ends flat
              cmd.save_slope = 1'b1;
              cmd.pc_inc     = 1'b1;
              state_nxt      = ST_D_PIECE;
            end else begin
              phase_nxt = PH_DSLOPE;
              state_nxt = ST_H_LOAD_RD;
            end
          end
          PH_DSLOPE: begin
            cmd.save_slope = 1'b1;
            cmd.pc_inc     = 1'b1;
            phase_nxt      = PH_DVAL;
            state_nxt      = ST_D_PIECE;
          end
          PH_EVAL: begin
            cmd.sum_add = 1'b1;
            cmd.pc_inc  = 1'b1;
            state_nxt   = ST_E_PIECE;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/ppe_dpath.sv =====
// ppe_dpath: registers, parameter and coefficient stores, shared multiply-add
// and result stage; depends on ppe_pkg, driven by ppe_ctrl
module ppe_dpath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ppe_pkg::ppe_cmd_t                 cmd,
  output ppe_pkg::ppe_stat_t                stat,
  input  logic [ppe_pkg::SLOT_W-1:0]        in_slot,
  input  logic signed [ppe_pkg::WORD_W-1:0] in_value,
  input  logic                              cfg_we,
  input  logic [ppe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ppe_pkg::WORD_W-1:0]        cfg_data,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic signed [ppe_pkg::WORD_W-1:0] out_response,
  output logic                              out_saturated
);

  // registers
  logic [ppe_pkg::COUNT_W-1:0]         count_r;
  logic [ppe_pkg::ORDERS_W-1:0]        orders_r;
  logic signed [ppe_pkg::WORD_W-1:0]   brk_r [ppe_pkg::BREAK_REGS];

  // stores
  logic signed [ppe_pkg::WORD_W-1:0]   pmem [ppe_pkg::PARAM_SLOTS];
  logic [ppe_pkg::PARAM_SLOTS-1:0]     pvld_r;
  logic signed [ppe_pkg::WORD_W-1:0]   prd_r;
  logic signed [ppe_pkg::WORD_W-1:0]   cmem [ppe_pkg::COEF_DEPTH];
  logic [ppe_pkg::COEF_DEPTH-1:0]      cvld_r;
  logic signed [ppe_pkg::WORD_W-1:0]   crd_r;

  // sequencing and arithmetic
  logic [ppe_pkg::PC_W-1:0]            pc_r;
  logic signed [ppe_pkg::WORD_W-1:0]   lo_r, hi_r, x_r;
  logic signed [ppe_pkg::T_W-1:0]      t_r;
  logic                                eval_r;
  logic [ppe_pkg::ORD_W-1:0]           j_r, k_r;
  logic [ppe_pkg::PIDX_W-1:0]          pidx_r;
  logic signed [ppe_pkg::WORD_W-1:0]   acc_r, endv_r, ends_r;
  logic signed [ppe_pkg::PROD_W-1:0]   p_r;
  logic signed [ppe_pkg::SUM_W-1:0]    sum_r;
  logic                                flag_r;
  logic                                out_valid_r;
  logic signed [ppe_pkg::WORD_W-1:0]   out_resp_r;
  logic                                out_sat_r;

  // combinational
  logic [ppe_pkg::PC_W-1:0]            n_used;
  logic [ppe_pkg::ORD_FIELD_W-1:0]     ord_raw;
  logic [ppe_pkg::ORD_W-1:0]           ord_cur;
  logic [ppe_pkg::PC_W+1:0]            hi_idx;
  logic signed [ppe_pkg::WORD_W-1:0]   brk_next;
  logic [ppe_pkg::CA_W-1:0]            row_base, crd_addr, cwr_addr;
  logic [ppe_pkg::ORD_W-1:0]           k_dec, rd_idx, term_m;
  logic                                slot_used, from_param, slot_ok;
  logic signed [ppe_pkg::WORD_W-1:0]   fill_val;
  logic signed [ppe_pkg::WORD_W+ppe_pkg::ORD_W:0] term_raw;
  ppe_pkg::sat_word_t                  term_sat, mac_sat, fin_sat;
  logic signed [ppe_pkg::WORD_W-1:0]   addend;
  logic signed [ppe_pkg::WIDE_W-1:0]   madd;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= ppe_pkg::RST_PIECE_COUNT;
      orders_r <= ppe_pkg::RST_PIECE_ORDERS;
      for (int b = 0; b < ppe_pkg::BREAK_REGS; b++) begin
        brk_r[b] <= ppe_pkg::RST_BREAKS[b];
      end
    end else if (cfg_we) begin
      unique case (cfg_index) inside
        ppe_pkg::CFG_PIECE_COUNT:  count_r  <= cfg_data[ppe_pkg::COUNT_W-1:0];
        ppe_pkg::CFG_PIECE_ORDERS: orders_r <= cfg_data[ppe_pkg::ORDERS_W-1:0];
        ppe_pkg::CFG_BREAK_0, ppe_pkg::CFG_BREAK_1, ppe_pkg::CFG_BREAK_2,
        ppe_pkg::CFG_BREAK_3, ppe_pkg::CFG_BREAK_4: begin
          brk_r[ppe_pkg::BI_W'(cfg_index - ppe_pkg::CFG_BREAK_0)] <= cfg_data;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    n_used  = (32'(count_r) > ppe_pkg::PIECE_LIM) ? ppe_pkg::PC_W'(ppe_pkg::PIECE_LIM)
                                                  : ppe_pkg::PC_W'(count_r);
    ord_raw = ppe_pkg::ORD_FIELD_W'(orders_r >> (ppe_pkg::ORD_FIELD_W * 32'(pc_r)));
    ord_cur = (32'(ord_raw) > ppe_pkg::MAX_ORDER) ? ppe_pkg::ORD_W'(ppe_pkg::MAX_ORDER)
                                                  : ppe_pkg::ORD_W'(ord_raw);
    // upper bound of the next piece
    hi_idx   = (ppe_pkg::PC_W+2)'(pc_r) + (ppe_pkg::PC_W+2)'(2);
    brk_next = '0;
    if (32'(hi_idx) < ppe_pkg::BREAK_REGS) begin
      brk_next = brk_r[ppe_pkg::BI_W'(hi_idx)];
    end
  end

  // parameter store, cleared entries read as zero
  assign slot_ok = 32'(in_slot) < ppe_pkg::PARAM_SLOTS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r <= '0;
    end else if (cmd.param_wr && slot_ok) begin
      pvld_r[ppe_pkg::PS_AW'(in_slot)] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.param_wr && slot_ok) begin
      pmem[ppe_pkg::PS_AW'(in_slot)] <= in_value;
    end
    if (32'(pidx_r) < ppe_pkg::PARAM_SLOTS && pvld_r[ppe_pkg::PS_AW'(pidx_r)]) begin
      prd_r <= pmem[ppe_pkg::PS_AW'(pidx_r)];
    end else begin
      prd_r <= '0;
    end
  end

  // coefficient store
  always_comb begin
    row_base   = ppe_pkg::CA_W'(32'(pc_r) * ppe_pkg::COEF_ROW);
    k_dec      = k_r - ppe_pkg::ORD_W'(1);
    rd_idx     = cmd.rd_top ? ord_cur : k_dec;
    crd_addr   = row_base + ppe_pkg::CA_W'(rd_idx);
    cwr_addr   = row_base + ppe_pkg::CA_W'(j_r);
    slot_used  = (pc_r < n_used) && (j_r <= ord_cur);
    from_param = (pc_r == '0) || (32'(j_r) >= 2);
    if (!slot_used) begin
      fill_val = '0;
    end else if (from_param) begin
      fill_val = prd_r;
    end else if (j_r == '0) begin
      fill_val = endv_r;
    end else begin
      fill_val = ends_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cvld_r <= '0;
    end else if (cmd.coef_wr) begin
      cvld_r[cwr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.coef_wr) begin
      cmem[cwr_addr] <= fill_val;
    end
    crd_r <= cvld_r[crd_addr] ? cmem[crd_addr] : '0;
  end

  // horner step: acc*t rounded plus addend, slope terms scaled by their power
  always_comb begin
    term_m   = cmd.h_load ? ord_cur : k_dec;
    term_raw = $signed({1'b0, term_m}) * crd_r;
    term_sat = ppe_pkg::sat_word(ppe_pkg::WIDE_W'(term_raw));
    addend   = cmd.slope ? term_sat.value : crd_r;
    madd     = ppe_pkg::WIDE_W'(p_r) + (ppe_pkg::WIDE_W'(addend) <<< ppe_pkg::FRAC_BITS)
             + ppe_pkg::WIDE_HALF;
    mac_sat  = ppe_pkg::sat_word(madd >>> ppe_pkg::FRAC_BITS);
    fin_sat  = ppe_pkg::sat_word(ppe_pkg::WIDE_W'(sum_r));
  end

  always_ff @(posedge clk) begin
    if (cmd.start_derive || cmd.start_eval) begin
      pc_r <= '0;
      lo_r <= brk_r[0];
      hi_r <= brk_r[1];
    end else if (cmd.pc_inc) begin
      pc_r <= pc_r + ppe_pkg::PC_W'(1);
      lo_r <= hi_r;
      hi_r <= brk_next;
    end
    if (cmd.start_derive) begin
      eval_r <= 1'b0;
      pidx_r <= '0;
      endv_r <= '0;
      ends_r <= '0;
    end
    if (cmd.start_eval) begin
      eval_r <= 1'b1;
      x_r    <= in_value;
      sum_r  <= '0;
      flag_r <= 1'b0;
    end
    if (cmd.piece_begin) begin
      t_r <= (eval_r ? ppe_pkg::T_W'(x_r) : ppe_pkg::T_W'(hi_r)) - ppe_pkg::T_W'(lo_r);
      j_r <= '0;
    end
    if (cmd.coef_wr) begin
      j_r <= j_r + ppe_pkg::ORD_W'(1);
      if (slot_used && from_param) begin
        pidx_r <= pidx_r + ppe_pkg::PIDX_W'(1);
      end
    end
    if (cmd.h_load) begin
      k_r   <= ord_cur;
      acc_r <= cmd.slope ? term_sat.value : crd_r;
    end
    if (cmd.h_mul) begin
      p_r <= acc_r * t_r;
    end
    if (cmd.h_add) begin
      k_r   <= k_dec;
      acc_r <= mac_sat.value;
      if (eval_r && mac_sat.clip) begin
        flag_r <= 1'b1;
      end
    end
    if (cmd.save_val) begin
      endv_r <= acc_r;
    end
    if (cmd.save_slope) begin
      ends_r <= (ord_cur == '0) ? '0 : acc_r;
    end
    if (cmd.sum_add) begin
      sum_r <= sum_r + ppe_pkg::SUM_W'(acc_r);
    end
    if (cmd.out_load) begin
      out_resp_r <= fin_sat.value;
      out_sat_r  <= flag_r | fin_sat.clip;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_response  = out_resp_r;
  assign out_saturated = out_sat_r;

  always_comb begin
    stat.pc_at_n   = pc_r >= n_used;
    stat.pc_at_max = 32'(pc_r) == ppe_pkg::MAX_PIECES;
    stat.in_range  = (x_r >= lo_r) && (x_r < hi_r);
    stat.fill_last = 32'(j_r) == ppe_pkg::COEF_ROW - 1;
    stat.fill_used = pc_r < n_used;
    stat.load_last = cmd.slope ? (32'(ord_cur) <= 1) : (ord_cur == '0);
    stat.add_last  = cmd.slope ? (32'(k_r) == 2) : (32'(k_r) == 1);
    stat.ord_zero  = ord_cur == '0;
    stat.out_free  = !out_valid_r || out_ready;
  end

endmodule

// ===== hdl/piecewise_poly_c1_evaluator_unit.sv =====
// piecewise_poly_c1_evaluator_unit: top level of the piecewise polynomial evaluator
// depends on ppe_pkg, ppe_ifs, ppe_ctrl and ppe_dpath
//
// channel  | role   | payload                               | taken when
// ---------+--------+---------------------------------------+-------------------
// in_ch    | sink   | action, param_index, operand_value    | valid && ready
// out_ch   | source | response, saturated (evaluate only)   | valid && ready
// cfg_ch   | sink   | index, data                           | valid (ready high)
//
// a parameter write is done in the idle state; an evaluate scans the pieces in use
// and runs a horner pass on the piece holding x, on one shared multiply-add that
// steps a multiply state then an add state per horner term, plus any wait for the
// output register; a derive fills the coefficient rows of every piece slot (MAX_PIECES
// of them), runs a value pass per piece in use and a slope pass when order > 0
// a new request is taken while a result waits in the output register
// reset clears registers to defaults and both stores to zero via valid bits
module piecewise_poly_c1_evaluator_unit (
  input  logic          clk,
  input  logic          rst_n,
  ppe_in_if.sink        in_ch,
  ppe_out_if.source     out_ch,
  ppe_cfg_if.sink       cfg_ch
);

  ppe_pkg::ppe_cmd_t  cmd;
  ppe_pkg::ppe_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  ppe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ppe_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_slot       (in_ch.param_index),
    .in_value      (in_ch.operand_value),
    .cfg_we        (cfg_ch.valid && cfg_ch.ready),
    .cfg_index     (cfg_ch.index),
    .cfg_data      (cfg_ch.data),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_response  (out_ch.response),
    .out_saturated (out_ch.saturated)
  );

  // an evaluate keeps the request side busy
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.action == ppe_pkg::ACT_EVAL) |=> !in_ch.ready)
    else $error("request taken right after an evaluate");

  // a result is only loaded from the finishing state
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> !$past(in_ch.ready))
    else $error("result appeared while idle");

  // writes and derives never make a result
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.action != ppe_pkg::ACT_EVAL && !out_ch.valid)
      |=> !out_ch.valid)
    else $error("result from a non-evaluate request");

endmodule
